// ===== rtl/btor_pkg.sv =====
package btor_pkg;

    // item kinds carried on the action field
    typedef enum logic [1:0] {
        ACT_RENDER = 2'd0,
        ACT_TEXT   = 2'd1,
        ACT_GLYPH  = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_TEXT_LENGTH  = 2'd2
    } t_cfg_reg;

    localparam int COORD_W   = 12;
    localparam int LEN_W     = 5;
    localparam int ROW_W     = 4;   // 16 rows per glyph
    localparam int Q_W       = 9;   // cell index before range check
    localparam int BAND_W    = 7;
    localparam int DY_W      = 14;

    localparam logic [31:0]        INK_COLOR    = 32'hff00_0000;
    localparam logic [COORD_W-1:0] WIDE_LIMIT   = 12'd480;
    localparam logic [BAND_W-1:0]  BAND_NARROW  = 7'd30;
    localparam logic [BAND_W-1:0]  BAND_WIDE    = 7'd70;
    localparam logic [COORD_W-1:0] LEFT_MARGIN  = 12'd10;
    localparam logic [3:0]         CELL_PITCH   = 4'd13;
    localparam logic [3:0]         GLYPH_COLS   = 4'd7;
    localparam logic [7:0]         CODE_BASE    = 8'd32;
    localparam logic [DY_W-1:0]    BAND_ROWS_1X = 14'd16;
    localparam logic [DY_W-1:0]    BAND_ROWS_2X = 14'd32;
    localparam logic [LEN_W-1:0]   LEN_RESET    = 5'd0;
    localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd480;

    // u / 13 as (u * 5042) >> 16, exact for any 12 bit u
    localparam logic [12:0] RECIP       = 13'd5042;
    localparam int          RECIP_SHIFT = 16;
    localparam int          PROD_W      = 25;

    // load fields that travel down the pipeline
    typedef struct packed {
        logic [1:0] action;
        logic [4:0] slot;
        logic [6:0] gidx;
        logic [3:0] gline;
        logic [7:0] wdata;
    } t_load;

    // band and margin results of the coordinate stage
    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] u;
        logic [ROW_W-1:0]   row;
    } t_geom;

    // cell column and hit flag
    typedef struct packed {
        logic       ok;
        logic [2:0] col;
    } t_cell;

endpackage

// ===== rtl/btor_ram.sv =====
module btor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/btor_geom.sv =====
module btor_geom (
    input  logic [btor_pkg::COORD_W-1:0] i_x,
    input  logic [btor_pkg::COORD_W-1:0] i_y,
    input  logic [btor_pkg::COORD_W-1:0] i_frame_width,
    input  logic [btor_pkg::COORD_W-1:0] i_frame_height,
    output btor_pkg::t_geom              o_geo
);

    logic                           in_frame;
    logic                           scale2;
    logic                           x_ok;
    logic [btor_pkg::COORD_W-1:0]   dx;
    logic [btor_pkg::BAND_W-1:0]    band;
    logic [btor_pkg::DY_W-1:0]      dy;
    logic                           y_ok;

    // frame clip and scale select
    assign in_frame = (i_x < i_frame_width) && (i_y < i_frame_height);
    assign scale2   = !(i_frame_width < btor_pkg::WIDE_LIMIT);

    // horizontal offset from the left margin, halved at scale two
    assign x_ok = (i_x >= btor_pkg::LEFT_MARGIN);
    assign dx   = i_x - btor_pkg::LEFT_MARGIN;

    // line offset inside the text band
    assign band = scale2 ? btor_pkg::BAND_WIDE : btor_pkg::BAND_NARROW;
    assign dy   = {2'b00, i_y} + {7'd0, band} - {2'b00, i_frame_height};
    assign y_ok = !dy[btor_pkg::DY_W-1] &&
                  (dy < (scale2 ? btor_pkg::BAND_ROWS_2X : btor_pkg::BAND_ROWS_1X));

    always_comb begin
        o_geo.ok  = in_frame && x_ok && y_ok;
        o_geo.u   = scale2 ? {1'b0, dx[btor_pkg::COORD_W-1:1]} : dx;
        o_geo.row = scale2 ? dy[4:1] : dy[3:0];
    end

endmodule

// ===== rtl/btor_cell.sv =====
module btor_cell #(
    parameter int MAX_TEXT = 24
) (
    input  logic                        i_ok,
    input  logic [btor_pkg::COORD_W-1:0] i_u,
    input  logic [btor_pkg::Q_W-1:0]    i_q,
    input  logic [btor_pkg::LEN_W-1:0]  i_text_length,
    output btor_pkg::t_cell             o_cell
);

    logic [btor_pkg::COORD_W:0] q13;
    logic [btor_pkg::COORD_W:0] rem;
    logic                       in_text;

    // remainder of u / 13 is the glyph column
    assign q13 = {4'd0, i_q} * {9'd0, btor_pkg::CELL_PITCH};
    assign rem = {1'b0, i_u} - q13;

    // cell must be within the drawn text and the store
    assign in_text = ({4'd0, i_text_length} < i_q ? 1'b0 : ({4'd0, i_text_length} != i_q))
                     && (i_q < btor_pkg::Q_W'(MAX_TEXT));

    always_comb begin
        o_cell.ok  = i_ok && in_text && (rem[3:0] < btor_pkg::GLYPH_COLS);
        o_cell.col = rem[2:0];
    end

endmodule

// ===== rtl/bitmap_text_overlay_renderer.sv =====
// Bitmap text overlay: returns the overlay color of one pixel per request.
// Input channel (i_in_valid / o_in_ready) carries three request kinds on
// i_action: render a pixel at i_pos_x / i_pos_y, write a character code into
// text slot i_text_slot, or write one glyph row (i_glyph_index, i_glyph_line).
// Only render requests produce a result on the output channel
// (o_out_valid / i_out_ready): o_pixel is 0xff000000 where a glyph bit covers
// the pixel and zero otherwise, o_ink flags the same.
// Throughput is one request per clock while the receiver does not stall. A render
// result passes through the input register, band/margin stage, divide-by-13
// multiplier, text store read, glyph store read, then the output register.
// Results keep request order; writes take effect for every later render.
// Configuration (frame size, text length) is written through i_cfg_we and
// takes effect at once; the user must write it while no request is in flight.
// Reset clears all stage valid bits and loads the register defaults
// (640 x 480, empty text); text and glyph stores keep no reset value and must
// be loaded before use. When the receiver stalls, the stalled result holds and
// the stages behind it fill up before o_in_ready drops.
module bitmap_text_overlay_renderer #(
    parameter int MAX_TEXT    = 24,
    parameter int GLYPH_COUNT = 96
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [btor_pkg::COORD_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_action,
    input  logic [btor_pkg::COORD_W-1:0] i_pos_x,
    input  logic [btor_pkg::COORD_W-1:0] i_pos_y,
    input  logic [4:0]                   i_text_slot,
    input  logic [6:0]                   i_glyph_index,
    input  logic [3:0]                   i_glyph_line,
    input  logic [7:0]                   i_write_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [31:0]                  o_pixel,
    output logic                         o_ink
);

    localparam int TEXT_AW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int GLYPH_IW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int GLYPH_AW = GLYPH_IW + btor_pkg::ROW_W;
    localparam int GLYPH_DEPTH = GLYPH_COUNT * 16;

    // configuration registers
    logic [btor_pkg::COORD_W-1:0] r_frame_width;
    logic [btor_pkg::COORD_W-1:0] r_frame_height;
    logic [btor_pkg::LEN_W-1:0]   r_text_length;

    // pipeline stage registers
    logic                         r1_v, r2_v, r3_v, r4_v, r5_v;
    btor_pkg::t_load              r1_ld, r2_ld, r3_ld, r4_ld;
    logic [btor_pkg::COORD_W-1:0] r1_x, r1_y;
    btor_pkg::t_geom              r2_geo;
    logic                         r3_ok;
    logic [btor_pkg::COORD_W-1:0] r3_u;
    logic [btor_pkg::Q_W-1:0]     r3_q;
    logic [btor_pkg::ROW_W-1:0]   r3_row;
    logic                         r4_ok;
    logic [2:0]                   r4_col;
    logic [btor_pkg::ROW_W-1:0]   r4_row;
    logic                         r5_render;
    logic                         r5_ok;
    logic [2:0]                   r5_col;
    logic                         r_out_valid;
    logic [31:0]                  r_pixel;
    logic                         r_ink;

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

    btor_pkg::t_geom              geo;
    btor_pkg::t_cell              cell_info;
    logic [btor_pkg::PROD_W-1:0]  prod;
    logic [6:0]                   slot_ext;
    logic                         text_we;
    logic [7:0]                   text_code;
    logic [7:0]                   gidx_ext;
    logic                         glyph_we;
    logic [7:0]                   code_off;
    logic                         code_ok;
    logic [7:0]                   glyph_bits;
    logic                         hit;

    // per-stage flow control, bubbles collapse
    assign rdy_o = !r_out_valid || i_out_ready;
    assign rdy5  = !r5_v || !r5_render || rdy_o;
    assign rdy4  = !r4_v || rdy5;
    assign rdy3  = !r3_v || rdy4;
    assign rdy2  = !r2_v || rdy3;
    assign rdy1  = !r1_v || rdy2;
    assign o_in_ready = rdy1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= btor_pkg::WIDTH_RESET;
            r_frame_height <= btor_pkg::HEIGHT_RESET;
            r_text_length  <= btor_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                btor_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                btor_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                btor_pkg::REG_TEXT_LENGTH:  r_text_length  <= i_cfg_data[btor_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_in_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            if (rdy5) r5_v <= r4_v;
            if (rdy_o) r_out_valid <= r5_v && r5_render;
        end
    end

    // stage 1: request register
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_ld.action <= i_action;
            r1_ld.slot   <= i_text_slot;
            r1_ld.gidx   <= i_glyph_index;
            r1_ld.gline  <= i_glyph_line;
            r1_ld.wdata  <= i_write_data;
            r1_x         <= i_pos_x;
            r1_y         <= i_pos_y;
        end
    end

    // stage 2: band and margin checks
    btor_geom u_geom (
        .i_x            (r1_x),
        .i_y            (r1_y),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_geo          (geo)
    );

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ld  <= r1_ld;
            r2_geo <= geo;
        end
    end

    // stage 3: cell index by reciprocal multiply
    assign prod = btor_pkg::PROD_W'(r2_geo.u) * btor_pkg::PROD_W'(btor_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_ld  <= r2_ld;
            r3_ok  <= r2_geo.ok;
            r3_u   <= r2_geo.u;
            r3_q   <= prod[btor_pkg::RECIP_SHIFT +: btor_pkg::Q_W];
            r3_row <= r2_geo.row;
        end
    end

    // stage 4: column, text store read and write
    btor_cell #(
        .MAX_TEXT (MAX_TEXT)
    ) u_cell (
        .i_ok          (r3_ok),
        .i_u           (r3_u),
        .i_q           (r3_q),
        .i_text_length (r_text_length),
        .o_cell        (cell_info)
    );

    assign slot_ext = {2'b00, r3_ld.slot};
    assign text_we  = r3_v && rdy4 && (r3_ld.action == btor_pkg::ACT_TEXT) &&
                      (slot_ext < 7'(MAX_TEXT));

    btor_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TEXT),
        .AW    (TEXT_AW)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (text_we),
        .i_waddr (slot_ext[TEXT_AW-1:0]),
        .i_wdata (r3_ld.wdata),
        .i_re    (rdy4),
        .i_raddr (r3_q[TEXT_AW-1:0]),
        .o_rdata (text_code)
    );

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_ld  <= r3_ld;
            r4_ok  <= cell_info.ok;
            r4_col <= cell_info.col;
            r4_row <= r3_row;
        end
    end

    // stage 5: glyph store read and write
    assign code_off = text_code - btor_pkg::CODE_BASE;
    assign code_ok  = (text_code >= btor_pkg::CODE_BASE) &&
                      ({1'b0, code_off} < 9'(GLYPH_COUNT));
    assign gidx_ext = {1'b0, r4_ld.gidx};
    assign glyph_we = r4_v && rdy5 && (r4_ld.action == btor_pkg::ACT_GLYPH) &&
                      ({1'b0, gidx_ext} < 9'(GLYPH_COUNT));

    btor_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_DEPTH),
        .AW    (GLYPH_AW)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr ({gidx_ext[GLYPH_IW-1:0], r4_ld.gline}),
        .i_wdata (r4_ld.wdata),
        .i_re    (rdy5),
        .i_raddr ({code_off[GLYPH_IW-1:0], r4_row}),
        .o_rdata (glyph_bits)
    );

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_render <= (r4_ld.action == btor_pkg::ACT_RENDER);
            r5_ok     <= r4_ok && code_ok;
            r5_col    <= r4_col;
        end
    end

    // output register: pick the glyph bit, msb is the leftmost column
    assign hit = r5_ok && glyph_bits[3'd7 - r5_col];

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_ink   <= hit;
            r_pixel <= hit ? btor_pkg::INK_COLOR : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pixel;
    assign o_ink       = r_ink;

endmodule

// ===== rtl/btor_chk.sv =====
module btor_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pixel,
    input logic        o_ink
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // pixel color agrees with the ink flag
    a_pixel_ink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel == (o_ink ? btor_pkg::INK_COLOR : 32'd0)))
        else $error("pixel value does not match ink flag");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel) && $stable(o_ink))
        else $error("stalled result changed");

    // with the result register empty, the pipeline never refuses a request
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused while output is free");

endmodule

bind bitmap_text_overlay_renderer btor_chk u_btor_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pixel     (o_pixel),
    .o_ink       (o_ink)
);
